// ----- rtl/lsra_pkg.sv -----
// Package for the linear scan register allocator.
// Holds sizes, register class constants, the sequencer state type and the item and result structs.
`default_nettype none
package lsra_pkg;
    localparam int REGS = 16;
    localparam int RIDX = $clog2(REGS);
    localparam int MAX_SLOTS = 4096;
    localparam int POS_BITS = 16;
    localparam logic [16:0] SLOT_FIRST = -17'sd8;
    localparam logic [16:0] SLOT_FLOOR = 17'(-8 - 8 * MAX_SLOTS);
    localparam logic [REGS-1:0] GP_AVAIL = REGS'(32'hFFCF);
    localparam logic [REGS-1:0] XMM_AVAIL = REGS'(32'hFFFF);
    localparam logic [REGS-1:0] CALLEE_GP_SYSV = REGS'(32'hF008);
    localparam logic [REGS-1:0] CALLEE_GP_WIN = REGS'(32'hF0C8);
    localparam logic [REGS-1:0] CALLEE_XMM_SYSV = REGS'(32'h0000);
    localparam logic [REGS-1:0] CALLEE_XMM_WIN = REGS'(32'hFFC0);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXPIRE,
        ST_PICK,
        ST_SEARCH,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [15:0] range_id;
        logic        granted;
        logic [3:0]  granted_reg;
        logic [16:0] spill_offset;
        logic        evicted;
        logic [15:0] evicted_id;
        logic [16:0] evicted_offset;
        logic [31:0] callee_used_mask;
        logic [15:0] spill_bytes;
    } result_t;

    typedef struct packed {
        logic        new_function;
        logic [15:0] range_id;
        logic [15:0] start_pos;
        logic [15:0] end_pos;
        logic        is_float;
        logic [4:0]  preferred_reg;
    } item_t;
endpackage
`default_nettype wire

// ----- rtl/lsra_if.sv -----
// Valid/ready channel interfaces, each carrying one payload.
// Payload type comes from lsra_pkg.
`default_nettype none
interface lsra_in_if;
    logic valid;
    logic ready;
    lsra_pkg::item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
    modport monitor (input valid, input data, input ready);
endinterface

interface lsra_out_if;
    logic valid;
    logic ready;
    lsra_pkg::result_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
    modport monitor (input valid, input data, input ready);
endinterface
`default_nettype wire

// ----- rtl/linear_scan_register_allocator_unit.sv -----
// Steps: every table entry is checked for expiry, then a free register is picked
// (preferred if free, else the lowest free non-callee-saved, else the lowest free);
// when the class is full, the valid entries are searched for the latest-ending one.
// Each step examines one registered table read per cycle. One interval at a time:
// ready only while idle, so a new interval is taken only after the last result is accepted.
// Reset clears valid bits and the usage mask, refills the free masks and resets the slot counter.
`default_nettype none
module linear_scan_register_allocator_unit (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cfg_we,
    input  wire logic cfg_wdata,
    lsra_in_if.sink   in_ch,
    lsra_out_if.source out_ch
);
    localparam int R = lsra_pkg::REGS;
    localparam int RI = lsra_pkg::RIDX;
    localparam int PB = lsra_pkg::POS_BITS;

    lsra_pkg::state_t state_reg, state_next;
    logic abi_reg;
    lsra_pkg::item_t item_reg;
    lsra_pkg::result_t res_reg, res_next;
    logic [R-1:0] gv_reg, gv_next, xv_reg, xv_next;
    logic [R-1:0] gf_reg, gf_next, xf_reg, xf_next;
    logic [15:0] gid_mem [R];
    logic [PB-1:0] gend_mem [R];
    logic [15:0] xid_mem [R];
    logic [PB-1:0] xend_mem [R];
    logic [15:0] gid_rd_reg, xid_rd_reg;
    logic [PB-1:0] gend_rd_reg, xend_rd_reg;
    logic [16:0] slot_reg, slot_next;
    logic [31:0] used_reg, used_next;
    logic [RI:0] cnt_reg, cnt_next;
    logic cand_ok_reg, cand_ok_next;
    logic [RI-1:0] cand_reg, cand_next;
    logic [PB-1:0] cend_reg, cend_next;
    logic [15:0] cid_reg, cid_next;
    logic wr_en;
    logic [RI-1:0] wr_idx;

    logic [RI-1:0] ci;
    logic [RI-1:0] pi;
    logic [PB-1:0] start, endp;
    logic [R-1:0] freem, callee, valid_c, pick_pool;
    logic [RI-1:0] low_reg;
    logic [RI-1:0] grant_r;
    logic [15:0] sel_id;
    logic [PB-1:0] sel_end;
    logic [16:0] slot_after;

    assign ci = cnt_reg[RI-1:0];
    assign pi = ci - 1'b1;
    assign start = item_reg.start_pos[PB-1:0];
    assign endp = item_reg.end_pos[PB-1:0];
    assign freem = item_reg.is_float ? xf_reg : gf_reg;
    assign valid_c = item_reg.is_float ? xv_reg : gv_reg;
    assign callee = item_reg.is_float
        ? (abi_reg ? lsra_pkg::CALLEE_XMM_WIN : lsra_pkg::CALLEE_XMM_SYSV)
        : (abi_reg ? lsra_pkg::CALLEE_GP_WIN : lsra_pkg::CALLEE_GP_SYSV);
    assign pick_pool = ((freem & ~callee) != '0) ? (freem & ~callee) : freem;
    assign sel_id = item_reg.is_float ? xid_rd_reg : gid_rd_reg;
    assign sel_end = item_reg.is_float ? xend_rd_reg : gend_rd_reg;
    assign slot_after = (slot_reg != lsra_pkg::SLOT_FLOOR) ? slot_reg - 17'd8 : slot_reg;

    always_comb
    begin
        low_reg = '0;
        for (int i = R - 1; i >= 0; i--)
        begin
            if (pick_pool[i])
            begin
                low_reg = RI'(i);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            abi_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            abi_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lsra_pkg::ST_IDLE;
            gv_reg <= '0;
            xv_reg <= '0;
            gf_reg <= lsra_pkg::GP_AVAIL;
            xf_reg <= lsra_pkg::XMM_AVAIL;
            slot_reg <= lsra_pkg::SLOT_FIRST;
            used_reg <= '0;
            cnt_reg <= '0;
            cand_ok_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            gv_reg <= gv_next;
            xv_reg <= xv_next;
            gf_reg <= gf_next;
            xf_reg <= xf_next;
            slot_reg <= slot_next;
            used_reg <= used_next;
            cnt_reg <= cnt_next;
            cand_ok_reg <= cand_ok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cand_reg <= cand_next;
        cend_reg <= cend_next;
        cid_reg <= cid_next;
        res_reg <= res_next;
        gid_rd_reg <= gid_mem[ci];
        gend_rd_reg <= gend_mem[ci];
        xid_rd_reg <= xid_mem[ci];
        xend_rd_reg <= xend_mem[ci];
        if (in_ch.valid && in_ch.ready)
        begin
            item_reg <= in_ch.data;
        end
        if (wr_en)
        begin
            if (item_reg.is_float)
            begin
                xid_mem[wr_idx] <= item_reg.range_id;
                xend_mem[wr_idx] <= endp;
            end
            else
            begin
                gid_mem[wr_idx] <= item_reg.range_id;
                gend_mem[wr_idx] <= endp;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        gv_next = gv_reg;
        xv_next = xv_reg;
        gf_next = gf_reg;
        xf_next = xf_reg;
        slot_next = slot_reg;
        used_next = used_reg;
        cnt_next = cnt_reg;
        cand_ok_next = cand_ok_reg;
        cand_next = cand_reg;
        cend_next = cend_reg;
        cid_next = cid_reg;
        res_next = res_reg;
        wr_en = 1'b0;
        wr_idx = '0;
        grant_r = '0;
        in_ch.ready = (state_reg == lsra_pkg::ST_IDLE);
        out_ch.valid = (state_reg == lsra_pkg::ST_OUT);
        unique case (state_reg)
            lsra_pkg::ST_IDLE:
            begin
                if (in_ch.valid)
                begin
                    cnt_next = '0;
                    state_next = lsra_pkg::ST_EXPIRE;
                    if (in_ch.data.new_function)
                    begin
                        gv_next = '0;
                        xv_next = '0;
                        gf_next = lsra_pkg::GP_AVAIL;
                        xf_next = lsra_pkg::XMM_AVAIL;
                        slot_next = lsra_pkg::SLOT_FIRST;
                        used_next = '0;
                    end
                end
            end
            lsra_pkg::ST_EXPIRE:
            begin
                if (cnt_reg != '0)
                begin
                    if (gv_reg[pi] && gend_rd_reg < start)
                    begin
                        gv_next[pi] = 1'b0;
                        gf_next[pi] = gf_reg[pi] | lsra_pkg::GP_AVAIL[pi];
                    end
                    if (xv_reg[pi] && xend_rd_reg < start)
                    begin
                        xv_next[pi] = 1'b0;
                        xf_next[pi] = xf_reg[pi] | lsra_pkg::XMM_AVAIL[pi];
                    end
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == (RI+1)'(R))
                begin
                    state_next = lsra_pkg::ST_PICK;
                end
            end
            lsra_pkg::ST_PICK:
            begin
                res_next = '0;
                res_next.range_id = item_reg.range_id;
                res_next.callee_used_mask = used_reg;
                res_next.spill_bytes = 16'(-slot_reg - 17'd8);
                cnt_next = '0;
                cand_ok_next = 1'b0;
                if (freem != '0)
                begin
                    if (item_reg.preferred_reg < 5'(R) && freem[item_reg.preferred_reg[RI-1:0]])
                    begin
                        grant_r = item_reg.preferred_reg[RI-1:0];
                    end
                    else
                    begin
                        grant_r = low_reg;
                    end
                    wr_en = 1'b1;
                    wr_idx = grant_r;
                    if (item_reg.is_float)
                    begin
                        xf_next[grant_r] = 1'b0;
                        xv_next[grant_r] = 1'b1;
                    end
                    else
                    begin
                        gf_next[grant_r] = 1'b0;
                        gv_next[grant_r] = 1'b1;
                    end
                    if (callee[grant_r])
                    begin
                        used_next[{item_reg.is_float, 4'(grant_r)}] = 1'b1;
                    end
                    res_next.granted = 1'b1;
                    res_next.granted_reg = 4'(grant_r);
                    res_next.callee_used_mask = used_next;
                    state_next = lsra_pkg::ST_OUT;
                end
                else
                begin
                    state_next = lsra_pkg::ST_SEARCH;
                end
            end
            lsra_pkg::ST_SEARCH:
            begin
                if (cnt_reg == (RI+1)'(R + 1))
                begin
                    if (cand_ok_reg && cend_reg > endp)
                    begin
                        grant_r = cand_reg;
                        wr_en = 1'b1;
                        wr_idx = cand_reg;
                        res_next.evicted = 1'b1;
                        res_next.evicted_id = cid_reg;
                        res_next.evicted_offset = slot_reg;
                        res_next.granted = 1'b1;
                        res_next.granted_reg = 4'(cand_reg);
                        if (callee[cand_reg])
                        begin
                            used_next[{item_reg.is_float, 4'(cand_reg)}] = 1'b1;
                        end
                    end
                    else
                    begin
                        res_next.spill_offset = slot_reg;
                    end
                    slot_next = slot_after;
                    res_next.spill_bytes = 16'(-slot_after - 17'd8);
                    res_next.callee_used_mask = used_next;
                    state_next = lsra_pkg::ST_OUT;
                end
                else
                begin
                    if (cnt_reg != '0 && valid_c[pi] && (!cand_ok_reg || sel_end > cend_reg))
                    begin
                        cand_ok_next = 1'b1;
                        cand_next = pi;
                        cend_next = sel_end;
                        cid_next = sel_id;
                    end
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            lsra_pkg::ST_OUT:
            begin
                if (out_ch.ready)
                begin
                    state_next = lsra_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lsra_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_ch.data = res_reg;
endmodule
`default_nettype wire

// ----- test/lsra_checker.sv -----
// Checker for the linear scan register allocator: watches the configuration port and
// both channels, keeps its own allocation state, predicts every result and compares.
// Depends on lsra_pkg and lsra_if.
`default_nettype none
module lsra_checker (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  cfg_we,
    input  wire logic  cfg_wdata,
    lsra_in_if.monitor  in_ch,
    lsra_out_if.monitor out_ch,
    output int         errors,
    output int         pending,
    output int         n_checked,
    output int         n_evicted,
    output int         n_spilled
);
    import lsra_pkg::*;

    localparam int CLS_GP = 0;
    localparam int CLS_XMM = 1;
    localparam int SLOT_LIMIT = -8 - 8 * MAX_SLOTS;

    logic            live [2][REGS];
    logic [15:0]     owner_id [2][REGS];
    logic [15:0]     owner_end [2][REGS];
    logic [REGS-1:0] free_regs [2];
    int              slot_next;
    logic [31:0]     callee_bits;
    logic            win_abi;
    result_t         awaited [$];

    function automatic void clear_allocation();
        for (int c = 0; c < 2; c++)
        begin
            for (int r = 0; r < REGS; r++)
            begin
                live[c][r] = 1'b0;
            end
        end
        free_regs[CLS_GP] = GP_AVAIL;
        free_regs[CLS_XMM] = XMM_AVAIL;
        slot_next = -8;
        callee_bits = '0;
    endfunction

    function automatic int claim_slot();
        int s;
        s = slot_next;
        if (slot_next - 8 >= SLOT_LIMIT)
        begin
            slot_next = slot_next - 8;
        end
        return s;
    endfunction

    function automatic int lowest_set(logic [REGS-1:0] m);
        for (int r = 0; r < REGS; r++)
        begin
            if (m[r])
            begin
                return r;
            end
        end
        return -1;
    endfunction

    function automatic result_t place_interval(item_t it);
        result_t         res;
        int              cls;
        int              reg_n;
        int              cand;
        logic [REGS-1:0] callee;
        logic [REGS-1:0] avail;
        res = '0;
        reg_n = -1;
        cand = -1;
        if (it.new_function)
        begin
            clear_allocation();
        end
        for (int c = 0; c < 2; c++)
        begin
            avail = (c == CLS_GP) ? GP_AVAIL : XMM_AVAIL;
            for (int r = 0; r < REGS; r++)
            begin
                if (live[c][r] && owner_end[c][r] < it.start_pos)
                begin
                    live[c][r] = 1'b0;
                    free_regs[c][r] = free_regs[c][r] | avail[r];
                end
            end
        end
        cls = it.is_float ? CLS_XMM : CLS_GP;
        if (it.is_float)
        begin
            callee = (win_abi ? CALLEE_XMM_WIN : CALLEE_XMM_SYSV) & XMM_AVAIL;
        end
        else
        begin
            callee = (win_abi ? CALLEE_GP_WIN : CALLEE_GP_SYSV) & GP_AVAIL;
        end
        if (free_regs[cls] != '0)
        begin
            if (it.preferred_reg < 16 && free_regs[cls][it.preferred_reg[3:0]])
            begin
                reg_n = int'(it.preferred_reg);
            end
            else if ((free_regs[cls] & ~callee) != '0)
            begin
                reg_n = lowest_set(free_regs[cls] & ~callee);
            end
            else
            begin
                reg_n = lowest_set(free_regs[cls]);
            end
            free_regs[cls][reg_n] = 1'b0;
            res.granted = 1'b1;
        end
        else
        begin
            for (int r = 0; r < REGS; r++)
            begin
                if (live[cls][r] && (cand < 0 || owner_end[cls][r] > owner_end[cls][cand]))
                begin
                    cand = r;
                end
            end
            if (cand >= 0 && owner_end[cls][cand] > it.end_pos)
            begin
                res.evicted = 1'b1;
                res.evicted_id = owner_id[cls][cand];
                res.evicted_offset = 17'(claim_slot());
                reg_n = cand;
                res.granted = 1'b1;
            end
            else
            begin
                res.spill_offset = 17'(claim_slot());
            end
        end
        if (res.granted)
        begin
            live[cls][reg_n] = 1'b1;
            owner_id[cls][reg_n] = it.range_id;
            owner_end[cls][reg_n] = it.end_pos;
            res.granted_reg = 4'(reg_n);
            if (callee[reg_n])
            begin
                callee_bits[cls * 16 + reg_n] = 1'b1;
            end
        end
        res.range_id = it.range_id;
        res.callee_used_mask = callee_bits;
        res.spill_bytes = 16'(-slot_next - 8);
        return res;
    endfunction

    task automatic report(string field, logic [63:0] got, logic [63:0] want);
        $display("mismatch on %s: got %0h, expected %0h (transfer %0d)",
                 field, got, want, n_checked);
        errors++;
    endtask

    task automatic compare_result(result_t got);
        result_t want;
        if (awaited.size() == 0)
        begin
            report("unexpected transfer", 64'(got.range_id), 64'd0);
            return;
        end
        want = awaited.pop_front();
        if (got.range_id !== want.range_id)
            report("range_id", 64'(got.range_id), 64'(want.range_id));
        if (got.granted !== want.granted)
            report("granted", 64'(got.granted), 64'(want.granted));
        if (got.granted_reg !== want.granted_reg)
            report("granted_reg", 64'(got.granted_reg), 64'(want.granted_reg));
        if (got.spill_offset !== want.spill_offset)
            report("spill_offset", 64'(got.spill_offset), 64'(want.spill_offset));
        if (got.evicted !== want.evicted)
            report("evicted", 64'(got.evicted), 64'(want.evicted));
        if (got.evicted_id !== want.evicted_id)
            report("evicted_id", 64'(got.evicted_id), 64'(want.evicted_id));
        if (got.evicted_offset !== want.evicted_offset)
            report("evicted_offset", 64'(got.evicted_offset), 64'(want.evicted_offset));
        if (got.callee_used_mask !== want.callee_used_mask)
            report("callee_used_mask", 64'(got.callee_used_mask),
                   64'(want.callee_used_mask));
        if (got.spill_bytes !== want.spill_bytes)
            report("spill_bytes", 64'(got.spill_bytes), 64'(want.spill_bytes));
        n_checked++;
        if (want.evicted)
            n_evicted++;
        if (!want.granted)
            n_spilled++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_allocation();
            win_abi = 1'b0;
            awaited.delete();
            errors = 0;
            n_checked = 0;
            n_evicted = 0;
            n_spilled = 0;
        end
        else
        begin
            if (cfg_we)
                win_abi = cfg_wdata;
            if (out_ch.valid && out_ch.ready)
                compare_result(out_ch.data);
            if (in_ch.valid && in_ch.ready)
                awaited = {awaited, place_interval(in_ch.data)};
        end
        pending = awaited.size();
    end
endmodule
`default_nettype wire

// ----- test/linear_scan_register_allocator_unit_tb.sv -----
// Top of the allocator testbench: clock, reset, interval stimulus and the verdict.
// Depends on lsra_pkg, lsra_if, lsra_checker and the allocator unit.
`default_nettype none
module linear_scan_register_allocator_unit_tb;
    import lsra_pkg::*;

    localparam int SETTLE = 2 * REGS + 8;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;
    int   errors;
    int   pending;
    int   n_checked;
    int   n_evicted;
    int   n_spilled;
    bit   quiet;
    bit   held;
    int   sent;

    lsra_in_if  in_ch ();
    lsra_out_if out_ch ();

    linear_scan_register_allocator_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    lsra_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .errors    (errors),
        .pending   (pending),
        .n_checked (n_checked),
        .n_evicted (n_evicted),
        .n_spilled (n_spilled)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic item_t interval(bit nf, int id, int s, int e, bit fl, int pref);
        item_t it;
        it.new_function = nf;
        it.range_id = 16'(id);
        it.start_pos = 16'(s);
        it.end_pos = 16'(e);
        it.is_float = fl;
        it.preferred_reg = 5'(pref);
        return it;
    endfunction

    task automatic offer(item_t it);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= it;
        @(posedge clk);
        while (!in_ch.ready)
        begin
            @(posedge clk);
        end
        sent++;
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_abi(bit v);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Receiver side: random stall bursts and one long hold-off partway through the run.
    initial
    begin
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!held && sent > 600)
            begin
                held = 1'b1;
                out_ch.ready <= 1'b0;
                repeat (300) @(posedge clk);
                out_ch.ready <= 1'b1;
            end
            else if (!quiet && $urandom_range(0, 3) == 0)
            begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
                out_ch.ready <= 1'b1;
            end
            else
            begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    initial
    begin
        int s;
        int len;
        int flen;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        quiet = 1'b0;
        sent = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: preferred hits and misses, reserved registers, extremes, ties.
        set_abi(1'b0);
        offer(interval(1, 16'hFFFF, 0, 65535, 0, 0));
        offer(interval(0, 0, 0, 65535, 0, 4));
        offer(interval(0, 1, 0, 65535, 0, 5));
        offer(interval(0, 2, 0, 65535, 1, 15));
        offer(interval(0, 3, 0, 65535, 1, 16));
        offer(interval(1, 10, 0, 100, 0, 16));
        for (int i = 0; i < 13; i++)
        begin
            offer(interval(0, 11 + i, 0, 100, 0, 16));
        end
        offer(interval(0, 30, 1, 50, 0, 3));
        offer(interval(0, 31, 2, 200, 0, 16));
        drain();
        set_abi(1'b1);
        offer(interval(0, 32, 101, 40, 0, 16));
        offer(interval(0, 33, 102, 65535, 1, 16));
        offer(interval(0, 34, 65535, 65535, 1, 16));
        drain();

        // Full class: fill every available GP register, then force a long series of evictions and spills.
        offer(interval(1, 100, 0, 65535, 0, 16));
        for (int i = 0; i < 13; i++)
        begin
            offer(interval(0, 101 + i, 0, 65535, 0, 16));
        end
        for (int i = 0; i < 200; i++)
        begin
            offer(interval(0, $urandom_range(0, 65535), 0, $urandom_range(0, 65535), 0,
                           $urandom_range(0, 16)));
        end
        drain();
        set_abi(1'b0);

        // Random functions of well-formed ascending intervals, with some noise.
        while (sent < 1700)
        begin
            if (sent > 1500)
                quiet = 1'b1;
            s = $urandom_range(0, 3) == 0 ? $urandom_range(60000, 65535)
                                          : $urandom_range(0, 2000);
            flen = $urandom_range(5, 60);
            len = $urandom_range(4, 60);
            for (int i = 0; i < flen; i++)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    offer(interval($urandom_range(0, 1), $urandom_range(0, 65535),
                                   $urandom_range(0, 65535), $urandom_range(0, 65535),
                                   $urandom_range(0, 1), $urandom_range(0, 16)));
                end
                else
                begin
                    offer(interval(i == 0, $urandom_range(0, 65535), s,
                                   (s + $urandom_range(0, len) > 65535) ? 65535
                                       : s + $urandom_range(0, len),
                                   $urandom_range(0, 2) == 0, $urandom_range(0, 16)));
                    if (s < 65535 && $urandom_range(0, 1) == 0)
                        s = s + 1;
                end
            end
            if ($urandom_range(0, 7) == 0)
            begin
                drain();
                set_abi($urandom_range(0, 1));
            end
        end
        drain();

        $display("Checked %0d allocation results over %0d intervals: %0d evictions, %0d spills.",
                 n_checked, sent, n_evicted, n_spilled);
        $display("Both ABI settings, full register classes and a long output stall were exercised.");
        if (errors == 0 && pending == 0)
        begin
            $display("[linear_scan_register_allocator_unit] OK");
        end
        else
        begin
            $display("[linear_scan_register_allocator_unit] ERROR");
        end
        $finish;
    end

    initial
    begin
        #30000000;
        $display("Timed out with %0d results outstanding.", pending);
        $display("[linear_scan_register_allocator_unit] ERROR");
        $finish;
    end
endmodule
`default_nettype wire

// ----- linear_scan_register_allocator_unit.f -----
rtl/lsra_pkg.sv
rtl/lsra_if.sv
rtl/linear_scan_register_allocator_unit.sv
test/lsra_checker.sv
test/linear_scan_register_allocator_unit_tb.sv
